### sv/avn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avn_pkg
// Shared types and constants for the audio volume normalizer.
// ----------------------------------------------------------------------------
package avn_pkg;

  localparam int NCH     = 8;    // channels
  localparam int WIN     = 64;   // history depth per channel
  localparam int CH_W    = 3;
  localparam int SMP_W   = 16;
  localparam int ACC_W   = 43;
  localparam int LVL_W   = 22;
  localparam int SCL_W   = 17;
  localparam int SUM_W   = 28;   // WIN * (2^LVL_W - 1) fits
  localparam int PTR_W   = 6;
  localparam int HADDR_W = CH_W + PTR_W;
  localparam int DIVN_W  = LVL_W + 16;

  localparam logic [ACC_W-1:0] ACC_MAX   = '1;
  localparam logic [SCL_W-1:0] UNITY     = 17'h10000;
  localparam logic [LVL_W-1:0] MIN_LEVEL = 22'd328;

  localparam logic [1:0] MODE_MEASURE = 2'd0;
  localparam logic [1:0] MODE_CLOSE   = 2'd1;
  localparam logic [1:0] MODE_APPLY   = 2'd2;

  localparam logic [1:0] REG_WINDOW   = 2'd0;
  localparam logic [1:0] REG_MAXLEVEL = 2'd1;
  localparam logic [1:0] REG_CHANNELS = 2'd2;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic load;
    logic sq;
    logic acc;
    logic mul;
    logic emit_smp;
    logic clr_c;
    logic rd;
    logic wr;
    logic div_avg;
    logic avg_latch;
    logic div_scl;
    logic emit_rep;
    logic next_c;
    logic ptr_adv;
  } avn_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       chan_ok;
    logic       c_last;
    logic       sqrt_busy;
    logic       div_busy;
    logic       out_free;
    logic       lim;
    logic       clr_busy;
  } avn_stat_t;

endpackage

### sv/avn_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avn_ram
// Single-port RAM, read-first (old data on a write), registered read.
// ----------------------------------------------------------------------------
module avn_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

### sv/avn_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avn_sqrt
// Iterative floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module avn_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [43:0] x,
  output logic        busy,
  output logic [21:0] root
);

  localparam int ITER = 22;

  logic        busy_r;
  logic [4:0]  cnt_r;
  logic [43:0] x_r;
  logic [25:0] rem_r;
  logic [21:0] root_r;
  logic [25:0] rem_s;
  logic [25:0] trial;

  assign rem_s = {rem_r[23:0], x_r[43:42]};
  assign trial = {2'b00, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'(ITER - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= x;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r <= {x_r[41:0], 2'b00};
      if (rem_s >= trial) begin
        rem_r  <= rem_s - trial;
        root_r <= {root_r[20:0], 1'b1};
      end else begin
        rem_r  <= rem_s;
        root_r <= {root_r[20:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

### sv/avn_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avn_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module avn_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [37:0] num,
  input  logic [21:0] den,
  output logic        busy,
  output logic [37:0] quo
);

  localparam int ITER = 38;

  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [37:0] q_r;
  logic [21:0] rem_r;
  logic [21:0] den_r;
  logic [22:0] rem_s;

  assign rem_s = {rem_r, q_r[37]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'(ITER - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      if (rem_s >= {1'b0, den_r}) begin
        rem_r <= 22'(rem_s - {1'b0, den_r});
        q_r   <= {q_r[36:0], 1'b1};
      end else begin
        rem_r <= rem_s[21:0];
        q_r   <= {q_r[36:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign quo  = q_r;

endmodule

### sv/avn_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avn_ctrl
// Sequencer: decodes each input transaction and steps the datapath.
// ----------------------------------------------------------------------------
module avn_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  avn_pkg::avn_stat_t  stat,
  output avn_pkg::avn_cmd_t   cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_SQ   = 4'd2;
  localparam logic [3:0] S_ACC  = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_SOUT = 4'd5;
  localparam logic [3:0] S_RD   = 4'd6;
  localparam logic [3:0] S_SQW  = 4'd7;
  localparam logic [3:0] S_DA   = 4'd8;
  localparam logic [3:0] S_DAW  = 4'd9;
  localparam logic [3:0] S_DS   = 4'd10;
  localparam logic [3:0] S_DSW  = 4'd11;
  localparam logic [3:0] S_EM   = 4'd12;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        // input is held off while the history is being cleared
        in_tready = !stat.clr_busy;
        if (in_tvalid && !stat.clr_busy) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.mode == avn_pkg::MODE_CLOSE) begin
          cmd.clr_c = 1'b1;
          state_nxt = S_RD;
        end else if (stat.mode == avn_pkg::MODE_MEASURE && stat.chan_ok) begin
          state_nxt = S_SQ;
        end else if (stat.mode == avn_pkg::MODE_APPLY && stat.chan_ok) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SOUT;
      end
      S_SOUT: begin
        if (stat.out_free) begin
          cmd.emit_smp = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_SQW;
      end
      S_SQW: begin
        if (!stat.sqrt_busy) begin
          cmd.wr    = 1'b1;
          state_nxt = S_DA;
        end
      end
      S_DA: begin
        cmd.div_avg = 1'b1;
        state_nxt   = S_DAW;
      end
      S_DAW: begin
        if (!stat.div_busy) begin
          cmd.avg_latch = 1'b1;
          state_nxt     = S_DS;
        end
      end
      S_DS: begin
        if (stat.lim) begin
          cmd.div_scl = 1'b1;
          state_nxt   = S_DSW;
        end else begin
          state_nxt = S_EM;
        end
      end
      S_DSW: begin
        if (!stat.div_busy) begin
          state_nxt = S_EM;
        end
      end
      S_EM: begin
        if (stat.out_free) begin
          cmd.emit_rep = 1'b1;
          if (stat.c_last) begin
            cmd.ptr_adv = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            cmd.next_c = 1'b1;
            state_nxt  = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // units are only started from their own launch states
  a_sqrt_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> !stat.sqrt_busy) else $error("sqrt restarted while busy");
  a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_avg || cmd.div_scl) |-> !stat.div_busy) else $error("divider restarted");
  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_rep || cmd.emit_smp) |-> stat.out_free) else $error("output overrun");

endmodule

### sv/avn_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avn_dp
// Datapath: config registers, energy accumulators, level history with
// running sums, sqrt and divider units, gain multiply and output register.
// ----------------------------------------------------------------------------
module avn_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  avn_pkg::avn_cmd_t  cmd,
  output avn_pkg::avn_stat_t stat,
  input  logic [23:0]        in_tdata,
  input  logic [1:0]         in_tuser,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [21:0]        cfg_data,
  input  logic               out_tready,
  output logic               out_tvalid,
  output logic [47:0]        out_tdata,
  output logic               out_tuser,
  output logic               out_tlast
);

  // configuration
  logic [6:0]  win_r;
  logic [21:0] maxl_r;
  logic [3:0]  nch_r;
  logic [6:0]  win_eff;
  logic [3:0]  nch_eff;
  logic [21:0] thr;

  always_comb begin
    if (win_r == 7'd0)                 win_eff = 7'd1;
    else if (win_r > 7'(avn_pkg::WIN)) win_eff = 7'(avn_pkg::WIN);
    else                               win_eff = win_r;
    if (nch_r == 4'd0)                 nch_eff = 4'd1;
    else if (nch_r > 4'(avn_pkg::NCH)) nch_eff = 4'(avn_pkg::NCH);
    else                               nch_eff = nch_r;
    thr = (maxl_r == 22'd0) ? avn_pkg::MIN_LEVEL : maxl_r;
  end

  logic win_wr;
  assign win_wr = cfg_valid && (cfg_index == avn_pkg::REG_WINDOW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= 7'd20;
      maxl_r <= 22'd65536;
      nch_r  <= 4'd2;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        avn_pkg::REG_WINDOW:   win_r  <= cfg_data[6:0];
        avn_pkg::REG_MAXLEVEL: maxl_r <= cfg_data;
        avn_pkg::REG_CHANNELS: nch_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // history clearing pass: one entry per cycle after reset and window writes
  logic                        clr_busy_r;
  logic [avn_pkg::HADDR_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (win_wr) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + {{(avn_pkg::HADDR_W-1){1'b0}}, 1'b1};
      if (clr_addr_r == '1) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // latched input transaction
  logic [1:0]                mode_r;
  logic [avn_pkg::CH_W-1:0]  chan_r;
  logic signed [15:0]        samp_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_tuser;
      chan_r <= in_tdata[2:0];
      samp_r <= $signed(in_tdata[18:3]);
    end
  end

  // per-channel state, shared history pointer and close channel index
  logic [avn_pkg::ACC_W-1:0] acc_r   [avn_pkg::NCH];
  logic [avn_pkg::SCL_W-1:0] scale_r [avn_pkg::NCH];
  logic [avn_pkg::SUM_W-1:0] sum_r   [avn_pkg::NCH];
  logic [avn_pkg::PTR_W-1:0] ptr_r;
  logic [avn_pkg::CH_W-1:0]  c_r;

  logic signed [31:0] sq_full;
  logic [30:0]        sq_r;
  logic [43:0]        acc_sum;
  logic signed [33:0] prod;
  logic signed [33:0] prod_r;
  logic               lim_s_r;
  logic [21:0]        avg_r;
  logic               lim_r;
  logic [21:0]        root;
  logic [21:0]        old_lvl;
  logic [21:0]        ram_rdata;
  logic               ram_we;
  logic [avn_pkg::HADDR_W-1:0] ram_addr;
  logic [21:0]        ram_wdata;
  logic               sqrt_busy;
  logic               div_busy;
  logic [37:0]        div_q;
  logic [37:0]        div_num;
  logic [21:0]        div_den;
  logic               c_last;

  assign sq_full = samp_r * samp_r;
  assign acc_sum = {1'b0, acc_r[chan_r]} + 44'(sq_r);
  assign prod    = samp_r * $signed({1'b0, scale_r[chan_r]});
  assign c_last  = ({1'b0, c_r} == (nch_eff - 4'd1));
  // the clearing pass leaves every entry zero, so the stored level is exact
  assign old_lvl = ram_rdata;

  always_ff @(posedge clk) begin
    if (cmd.sq) begin
      sq_r <= sq_full[30:0];
    end
    if (cmd.mul) begin
      prod_r  <= prod;
      lim_s_r <= scale_r[chan_r] < avn_pkg::UNITY;
    end
    if (cmd.avg_latch) begin
      avg_r <= div_q[21:0];
      lim_r <= div_q[21:0] > thr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < avn_pkg::NCH; i++) begin
        acc_r[i]   <= '0;
        scale_r[i] <= avn_pkg::UNITY;
        sum_r[i]   <= '0;
      end
      ptr_r  <= '0;
      c_r    <= '0;
    end else begin
      if (cmd.acc) begin
        acc_r[chan_r] <= acc_sum[43] ? avn_pkg::ACC_MAX : acc_sum[42:0];
      end
      if (cmd.clr_c) begin
        c_r <= '0;
      end else if (cmd.next_c) begin
        c_r <= c_r + 3'd1;
      end
      if (cmd.wr) begin
        acc_r[c_r] <= '0;
        sum_r[c_r] <= sum_r[c_r] - 28'(old_lvl) + 28'(root);
      end
      if (cmd.emit_rep) begin
        scale_r[c_r] <= lim_r ? div_q[16:0] : avn_pkg::UNITY;
      end
      if (win_wr) begin
        ptr_r <= '0;
        for (int i = 0; i < avn_pkg::NCH; i++) begin
          sum_r[i] <= '0;
        end
      end else if (cmd.ptr_adv) begin
        if ({1'b0, ptr_r} + 7'd1 >= win_eff) begin
          ptr_r <= '0;
        end else begin
          ptr_r <= ptr_r + 6'd1;
        end
      end
    end
  end

  assign ram_we    = clr_busy_r || cmd.wr;
  assign ram_addr  = clr_busy_r ? clr_addr_r : {c_r, ptr_r};
  assign ram_wdata = clr_busy_r ? 22'd0 : root;

  avn_ram #(
    .WIDTH (avn_pkg::LVL_W),
    .DEPTH (avn_pkg::NCH * avn_pkg::WIN)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  avn_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.rd),
    .x     ({1'b0, acc_r[c_r]}),
    .busy  (sqrt_busy),
    .root  (root)
  );

  always_comb begin
    if (cmd.div_scl) begin
      div_num = {thr, 16'h0000};
      div_den = avg_r;
    end else begin
      div_num = 38'(sum_r[c_r]);
      div_den = 22'(win_eff);
    end
  end

  avn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_avg || cmd.div_scl),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_q)
  );

  // output register
  logic        ov_r;
  logic        ok_r;
  logic        ol_r;
  logic [47:0] od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.emit_smp || cmd.emit_rep) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_smp) begin
      ok_r <= avn_pkg::KIND_SAMPLE;
      ol_r <= 1'b1;
      od_r <= {6'd0, lim_s_r, 22'd0, prod_r[31:16], chan_r};
    end else if (cmd.emit_rep) begin
      ok_r <= avn_pkg::KIND_REPORT;
      ol_r <= c_last;
      od_r <= {6'd0, lim_r, avg_r, 16'd0, c_r};
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = ok_r;
  assign out_tlast  = ol_r;
  assign out_tdata  = od_r;

  assign stat.mode      = mode_r;
  assign stat.chan_ok   = {1'b0, chan_r} < nch_eff;
  assign stat.c_last    = c_last;
  assign stat.sqrt_busy = sqrt_busy;
  assign stat.div_busy  = div_busy;
  assign stat.out_free  = !ov_r || out_tready;
  assign stat.lim       = lim_r;
  assign stat.clr_busy  = clr_busy_r;

  a_ptr_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, ptr_r} < win_eff) else $error("history pointer outside window");
  a_no_load_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !clr_busy_r) else $error("transaction taken during history clear");
  a_scale_below_unity: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_rep && lim_r) |-> (div_q < 38'(avn_pkg::UNITY)))
    else $error("reduced gain not below unity");

endmodule

### sv/audio_volume_normalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_volume_normalizer
// Per-channel level measurement, windowed averaging and gain limiting.
//
// channel  handshake          payload
// in_      tvalid/tready      tuser: mode; tdata: channel, sample_in
// out_     tvalid/tready      tuser: kind; tlast: last; tdata: see port
// cfg_     valid/ready        index 0 window_len, 1 max_level, 2 num_channels
//
// Measure: decode, square, accumulate. Apply: decode, multiply, then an emit
// state that waits for the output register. Close, per channel: sqrt, average
// divide, launch and emit states, and a scale divide when the gain is reduced.
// Reset is synchronous; a clearing pass of the history follows reset and every
// window_len write, holding off input and config meanwhile. A stalled output
// holds the sequencer in its emit state; input waits.
// ----------------------------------------------------------------------------
module audio_volume_normalizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [2:0] channel, [18:3] sample_in, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [2:0] out_channel, [18:3] sample_out,
                                  // [40:19] avg_level, [41] limiting
  output logic        out_tuser,  // [0] kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [21:0] cfg_data
);

  avn_pkg::avn_cmd_t  cmd;
  avn_pkg::avn_stat_t stat;

  assign cfg_ready = !stat.clr_busy;

  avn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  avn_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### tb/tb_audio_volume_normalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_volume_normalizer
// Streams measure/close/apply transactions into the normalizer under random
// idling on both sides, predicts levels, averages and scaled samples per
// channel, and checks every output transaction field by field.
// ----------------------------------------------------------------------------
module tb_audio_volume_normalizer;

  typedef struct packed {
    logic [1:0]                mode;
    logic [avn_pkg::CH_W-1:0]  chan;
    logic [avn_pkg::SMP_W-1:0] smp;
  } norm_item_t;

  typedef struct packed {
    logic                      kind;
    logic [avn_pkg::CH_W-1:0]  chan;
    logic [avn_pkg::SMP_W-1:0] smp;
    logic [avn_pkg::LVL_W-1:0] avg;
    logic                      lim;
    logic                      last;
  } norm_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [21:0] cfg_data;

  audio_volume_normalizer DUT (.*);

  // predictor state
  logic [6:0]                win_reg;
  logic [21:0]               thr_reg;
  logic [3:0]                nch_reg;
  logic [avn_pkg::ACC_W-1:0] energy [avn_pkg::NCH];
  logic [avn_pkg::LVL_W-1:0] hist [avn_pkg::NCH][avn_pkg::WIN];
  int unsigned               hptr;
  logic [avn_pkg::SCL_W-1:0] gain [avn_pkg::NCH];

  norm_item_t pending_items[$];
  norm_res_t  expected_results[$];
  int  n_errors;
  bit  quiet_tail;
  bit  in_taken;
  int  in_gap, out_gap;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("[audio_volume_normalizer] ERROR");
    $finish;
  end

  function automatic int unsigned active_channels();
    if (nch_reg == 0) return 1;
    if (nch_reg > avn_pkg::NCH) return avn_pkg::NCH;
    return nch_reg;
  endfunction

  function automatic int unsigned active_window();
    if (win_reg == 0) return 1;
    if (win_reg > avn_pkg::WIN) return avn_pkg::WIN;
    return win_reg;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic clear_levels();
    for (int c = 0; c < avn_pkg::NCH; c++)
      for (int i = 0; i < avn_pkg::WIN; i++) hist[c][i] = '0;
    hptr = 0;
  endtask

  task automatic predict_normalizer(input norm_item_t it);
    int unsigned nch, w, p;
    longint signed s, prod, q;
    longint unsigned sq, tot, lvl, sum, avg, thr;
    norm_res_t r;
    nch = active_channels();
    w = active_window();
    s = $signed(it.smp);
    if (it.mode == avn_pkg::MODE_MEASURE) begin
      if (it.chan >= nch) return;
      sq = s * s;
      tot = energy[it.chan] + sq;
      energy[it.chan] = (tot > avn_pkg::ACC_MAX) ? avn_pkg::ACC_MAX
                                                 : tot[avn_pkg::ACC_W-1:0];
    end else if (it.mode == avn_pkg::MODE_CLOSE) begin
      p = (hptr < w) ? hptr : 0;
      thr = (thr_reg == 0) ? avn_pkg::MIN_LEVEL : thr_reg;
      for (int c = 0; c < nch; c++) begin
        lvl = floor_sqrt(energy[c]);
        if (lvl > 64'h3FFFFF) lvl = 64'h3FFFFF;
        hist[c][p] = lvl[avn_pkg::LVL_W-1:0];
        energy[c] = '0;
        sum = 0;
        for (int i = 0; i < w; i++) sum += hist[c][i];
        avg = sum / w;
        r = '0;
        r.kind = avn_pkg::KIND_REPORT;
        r.chan = c[avn_pkg::CH_W-1:0];
        r.avg = avg[avn_pkg::LVL_W-1:0];
        r.lim = avg > thr;
        r.last = (c + 1 == nch);
        gain[c] = r.lim ? avn_pkg::SCL_W'((thr << 16) / avg) : avn_pkg::UNITY;
        expected_results.push_back(r);
      end
      p++;
      hptr = (p >= w) ? 0 : p;
    end else if (it.mode == avn_pkg::MODE_APPLY) begin
      if (it.chan >= nch) return;
      prod = s * longint'(gain[it.chan]);
      q = prod >>> 16;  // arithmetic shift is floor division
      r = '0;
      r.kind = avn_pkg::KIND_SAMPLE;
      r.chan = it.chan;
      r.smp = q[avn_pkg::SMP_W-1:0];
      r.lim = gain[it.chan] < avn_pkg::UNITY;
      r.last = 1'b1;
      expected_results.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h, expected %0h", what, got, want);
    n_errors++;
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
      in_taken = 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // hold
    end else if (in_gap > 0) begin
      in_gap--;
      in_tvalid <= 1'b0;
    end else if (pending_items.size() > 0 && !quiet_tail && $urandom_range(0, 19) == 0) begin
      in_gap = $urandom_range(1, 17) - 1;
      in_tvalid <= 1'b0;
    end else if (pending_items.size() > 0) begin
      norm_item_t it;
      it = pending_items.pop_front();
      in_taken = 1'b0;
      in_tvalid <= 1'b1;
      in_tuser <= it.mode;
      in_tdata <= {5'b0, it.smp, it.chan};
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      in_taken = 1'b1;
      predict_normalizer('{mode: in_tuser, chan: in_tdata[2:0], smp: in_tdata[18:3]});
    end
  end

  // receiver idling
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap = 0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
      out_gap = $urandom_range(1, 17) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    norm_res_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction", out_tdata, 0);
      end else begin
        w = expected_results.pop_front();
        if (out_tuser !== w.kind) report_mismatch("kind", out_tuser, w.kind);
        if (out_tdata[2:0] !== w.chan) report_mismatch("channel", out_tdata[2:0], w.chan);
        if (out_tdata[18:3] !== w.smp) report_mismatch("sample", out_tdata[18:3], w.smp);
        if (out_tdata[40:19] !== w.avg) report_mismatch("avg_level", out_tdata[40:19], w.avg);
        if (out_tdata[41] !== w.lim) report_mismatch("limiting", out_tdata[41], w.lim);
        if (out_tdata[47:42] !== 6'b0) report_mismatch("pad", out_tdata[47:42], 0);
        if (out_tlast !== w.last) report_mismatch("last", out_tlast, w.last);
      end
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (600) @(posedge clk);  // closes emit nothing after the last result
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [21:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == avn_pkg::REG_WINDOW) begin
      win_reg = val[6:0];
      clear_levels();
    end else if (idx == avn_pkg::REG_MAXLEVEL) begin
      thr_reg = val;
    end else if (idx == avn_pkg::REG_CHANNELS) begin
      nch_reg = val[3:0];
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_item(input logic [1:0] m, input logic [2:0] c, input logic [15:0] s);
    pending_items.push_back('{mode: m, chan: c, smp: s});
  endtask

  // well-formed buffer: measures, close, applies; some noise mixed in
  task automatic queue_buffer(input int n, input bit loud);
    logic [15:0] s;
    for (int i = 0; i < n; i++) begin
      s = loud ? ($urandom_range(0, 1) ? 16'(16'h8000 + $urandom_range(0, 4000))
                                       : 16'(16'h7FFF - $urandom_range(0, 4000)))
               : 16'($urandom);
      if ($urandom_range(0, 24) == 0) queue_item(2'd3, 3'($urandom), 16'($urandom));
      else queue_item(avn_pkg::MODE_MEASURE, 3'($urandom), s);
    end
    queue_item(avn_pkg::MODE_CLOSE, 3'($urandom), 16'($urandom));
    for (int i = 0; i < n; i++) queue_item(avn_pkg::MODE_APPLY, 3'($urandom), 16'($urandom));
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    n_errors = 0;
    quiet_tail = 1'b0;
    in_taken = 1'b0;
    win_reg = 7'd20;
    thr_reg = 22'd65536;
    nch_reg = 4'd2;
    for (int c = 0; c < avn_pkg::NCH; c++) begin
      energy[c] = '0;
      gain[c] = avn_pkg::UNITY;
    end
    clear_levels();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset config, extremes, ignored items
    queue_item(avn_pkg::MODE_APPLY, 3'd0, 16'h7FFF);
    queue_item(avn_pkg::MODE_MEASURE, 3'd0, 16'h8000);
    queue_item(avn_pkg::MODE_MEASURE, 3'd1, 16'h7FFF);
    queue_item(avn_pkg::MODE_MEASURE, 3'd5, 16'h1234);
    queue_item(2'd3, 3'd0, 16'h1111);
    queue_item(avn_pkg::MODE_CLOSE, 3'd7, 16'hFFFF);
    queue_item(avn_pkg::MODE_APPLY, 3'd0, 16'h8000);
    queue_item(avn_pkg::MODE_APPLY, 3'd1, 16'hFFFF);
    queue_item(avn_pkg::MODE_APPLY, 3'd7, 16'h0001);
    wait_drained();

    // all channels, window 1, zero threshold -> strong limiting
    write_reg(avn_pkg::REG_CHANNELS, 22'd8);
    write_reg(avn_pkg::REG_WINDOW, 22'd1);
    write_reg(avn_pkg::REG_MAXLEVEL, 22'd0);
    for (int c = 0; c < 8; c++)
      queue_item(avn_pkg::MODE_MEASURE, 3'(c), c[0] ? 16'h8000 : 16'h7FFF);
    queue_item(avn_pkg::MODE_CLOSE, 3'd0, 16'h0);
    for (int c = 0; c < 8; c++)
      queue_item(avn_pkg::MODE_APPLY, 3'(c), c[0] ? 16'h8000 : 16'h7FFF);
    queue_item(avn_pkg::MODE_APPLY, 3'd3, 16'hFFFF);
    wait_drained();

    // randomized phases through several register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(avn_pkg::REG_WINDOW, 22'd0);
                 write_reg(avn_pkg::REG_MAXLEVEL, 22'd328);
                 write_reg(avn_pkg::REG_CHANNELS, 22'd0); end
        1: begin write_reg(avn_pkg::REG_WINDOW, 22'd64);
                 write_reg(avn_pkg::REG_MAXLEVEL, 22'h3FFFFF);
                 write_reg(avn_pkg::REG_CHANNELS, 22'd15); end
        2: begin write_reg(avn_pkg::REG_WINDOW, 22'h7F);
                 write_reg(avn_pkg::REG_MAXLEVEL, 22'd2097152);
                 write_reg(avn_pkg::REG_CHANNELS, 22'd3); end
        3: begin write_reg(avn_pkg::REG_WINDOW, 22'd3);
                 write_reg(avn_pkg::REG_MAXLEVEL, 22'd20000);
                 write_reg(avn_pkg::REG_CHANNELS, 22'd4); end
        4: begin write_reg(avn_pkg::REG_WINDOW, 22'($urandom_range(1, 8)));
                 write_reg(avn_pkg::REG_MAXLEVEL, 22'($urandom_range(328, 60000)));
                 write_reg(avn_pkg::REG_CHANNELS, 22'($urandom_range(1, 8))); end
        default: begin write_reg(avn_pkg::REG_CHANNELS, 22'd8); quiet_tail = 1'b1; end
      endcase
      for (int b = 0; b < 4; b++) begin
        queue_buffer($urandom_range(4, 12), $urandom_range(0, 1));
        // at least once the sender holds off until the block has caught up
        if (b == 1) while (pending_items.size() > 0 || in_tvalid) @(posedge clk);
        if (b == 1) while (expected_results.size() > 0) @(posedge clk);
      end
      wait_drained();
    end

    if (n_errors == 0) begin
      $display("[audio_volume_normalizer] OK");
    end else begin
      $display("[audio_volume_normalizer] ERROR");
    end
    $finish;
  end

endmodule
